>>> design/lile_pkg.sv
// Shared types, constants and the slot mapping of the indexed list engine.
package lile_pkg;

   localparam int DEPTH      = 1024;
   localparam int VALUE_BITS = 32;
   localparam int ADDR_BITS  = $clog2(DEPTH);
   localparam int CNT_BITS   = ADDR_BITS + 1;

   localparam logic [VALUE_BITS-1:0] EMPTY_CODE   = {1'b1, {(VALUE_BITS-1){1'b0}}};
   localparam logic [VALUE_BITS-1:0] LOWEST_VALUE = {1'b1, {(VALUE_BITS-2){1'b0}}, 1'b1};
   localparam logic [CNT_BITS-1:0]   NONE_TOUCHED = {CNT_BITS{1'b1}};
   localparam logic [CNT_BITS-1:0]   CAP_MAX      = CNT_BITS'(DEPTH);
   localparam logic [CNT_BITS-1:0]   CAP_MIN      = CNT_BITS'(1);

   typedef enum logic [1:0] {
      KIND_INSERT  = 2'd0,
      KIND_REMOVE  = 2'd1,
      KIND_REPLACE = 2'd2,
      KIND_READ    = 2'd3
   } lile_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_EMPTY = 2'd3
   } lile_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_EXEC,
      ST_SCAN_READ,
      ST_SCAN_PEND,
      ST_SCAN_ELEM,
      ST_PACK_READ,
      ST_PACK_WRITE,
      ST_READ_WAIT
   } lile_state_type;

   typedef struct packed {
      lile_kind_type                kind;
      logic [ADDR_BITS-1:0]         position;
      logic signed [VALUE_BITS-1:0] item_value;
   } lile_req_type;

   typedef struct packed {
      lile_status_type              status;
      logic signed [VALUE_BITS-1:0] read_value;
      logic                         compacted;
      logic [CNT_BITS-1:0]          list_length;
   } lile_rsp_type;

   // Zig-zag map: even index to idx/2, odd index to cap - (idx+1)/2.
   function automatic logic [ADDR_BITS-1:0] slot_of(input logic [CNT_BITS-1:0] idx,
                                                    input logic [CNT_BITS-1:0] cap);
      logic [CNT_BITS-1:0] half;
      logic [CNT_BITS-1:0] odd_slot;
      half     = idx >> 1;
      odd_slot = cap - half - CNT_BITS'(1);
      return idx[0] ? odd_slot[ADDR_BITS-1:0] : half[ADDR_BITS-1:0];
   endfunction

endpackage

>>> design/lazy_indexed_list_engine.sv
// Top level of the lazy indexed list engine: sequencer, slot mapper and list stores.
//
// The engine holds a positional list of signed values in an element store and a
// pending-insert store, with logical index i mapped zig-zag onto physical slots
// (even i to i/2, odd i to capacity-(i+1)/2). A transaction is accepted when start
// is high and busy is low; its result appears on rsp_data for exactly one cycle,
// marked by rsp_valid, and the receiver must take it then since there is no
// back-pressure. Insert, remove and replace below the lowest index touched so far,
// and any of them that fails, go from acceptance through EXEC straight to the
// registered result strobe (at most one slot write). One at or above that index,
// and every read, first runs a compaction that walks the capacity slots twice
// through one shared slot mapper and one-read, one-write stores: a scan pass
// through SCAN_READ, SCAN_PEND and SCAN_ELEM per slot, then a pack pass through
// PACK_READ and PACK_WRITE per slot. After reset, and after every write of the
// capacity register, the element and pending stores are cleared, all 1024 slots,
// one slot a cycle while busy is high; a capacity write empties the list.
module lazy_indexed_list_engine
   import lile_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  lile_req_type        req_data,
   output logic                rsp_valid,
   output lile_rsp_type        rsp_data,
   input  logic                csr_write_en,
   input  logic [CNT_BITS-1:0] csr_write_data
);

   // Sequencer and list state
   lile_state_type      state_ff, state_in;
   logic [CNT_BITS-1:0] walk_ff, walk_in;        // slot / logical walk counter
   logic [CNT_BITS-1:0] fill_ff, fill_in;        // compacted items written so far
   logic [CNT_BITS-1:0] capacity_ff, capacity_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [CNT_BITS-1:0] lowest_ff, lowest_in;
   logic                done_ff, done_in;        // compaction ran for this transaction
   lile_req_type        req_ff, req_in;
   logic                rsp_valid_ff, rsp_valid_in;
   lile_rsp_type        rsp_ff, rsp_in;

   // Shared slot mapper
   logic [CNT_BITS-1:0]  slot_idx;
   logic [ADDR_BITS-1:0] slot;

   // Store ports
   logic                  elem_wr_en, elem_rd_en;
   logic [ADDR_BITS-1:0]  elem_wr_addr;
   logic [VALUE_BITS-1:0] elem_wr_data, elem_rd_data;
   logic                  pend_wr_en, pend_rd_en;
   logic [ADDR_BITS-1:0]  pend_wr_addr;
   logic [VALUE_BITS-1:0] pend_wr_data, pend_rd_data;
   logic                  scr_wr_en, scr_rd_en;
   logic [VALUE_BITS-1:0] scr_wr_data, scr_rd_data;

   // Operation decode
   logic [CNT_BITS-1:0]   pos_ext;
   lile_status_type       status_now;
   logic                  need_compact;
   logic [VALUE_BITS-1:0] value_sat;
   logic [CNT_BITS-1:0]   cap_clamped;
   logic                  walk_last;

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign pos_ext   = {1'b0, req_ff.position};
   assign walk_last = (walk_ff == capacity_ff - CNT_BITS'(1));

   // The mapper follows the walk counter during compaction, else the addressed index.
   assign slot_idx = (state_ff == ST_SCAN_READ || state_ff == ST_SCAN_PEND ||
                      state_ff == ST_SCAN_ELEM || state_ff == ST_PACK_READ ||
                      state_ff == ST_PACK_WRITE) ? walk_ff : pos_ext;
   assign slot     = slot_of(slot_idx, capacity_ff);

   // Keep the empty marker out of the data: saturate it to the lowest usable value.
   assign value_sat = (req_ff.item_value == EMPTY_CODE) ? LOWEST_VALUE : req_ff.item_value;

   always_comb begin
      if (csr_write_data == '0) begin
         cap_clamped = CAP_MIN;
      end else if (csr_write_data > CAP_MAX) begin
         cap_clamped = CAP_MAX;
      end else begin
         cap_clamped = csr_write_data;
      end
   end

   // Status does not depend on compaction, so it is evaluated once per visit to EXEC.
   always_comb begin
      if (req_ff.kind == KIND_INSERT) begin
         if (count_ff >= capacity_ff) begin
            status_now = STATUS_FULL;
         end else if (pos_ext > count_ff) begin
            status_now = STATUS_RANGE;
         end else begin
            status_now = STATUS_OK;
         end
      end else begin
         if (count_ff == '0) begin
            status_now = STATUS_EMPTY;
         end else if (pos_ext >= count_ff) begin
            status_now = STATUS_RANGE;
         end else begin
            status_now = STATUS_OK;
         end
      end
      if (req_ff.kind == KIND_READ) begin
         need_compact = !done_ff;
      end else begin
         need_compact = (status_now == STATUS_OK) && (pos_ext >= lowest_ff);
      end
   end

   lile_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_elem_ram (
      .clock   (clock),
      .wr_en   (elem_wr_en),
      .wr_addr (elem_wr_addr),
      .wr_data (elem_wr_data),
      .rd_en   (elem_rd_en),
      .rd_addr (slot),
      .rd_data (elem_rd_data)
   );

   lile_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_pend_ram (
      .clock   (clock),
      .wr_en   (pend_wr_en),
      .wr_addr (pend_wr_addr),
      .wr_data (pend_wr_data),
      .rd_en   (pend_rd_en),
      .rd_addr (slot),
      .rd_data (pend_rd_data)
   );

   // Scratch holds the compacted list in plain logical order.
   lile_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_scr_ram (
      .clock   (clock),
      .wr_en   (scr_wr_en),
      .wr_addr (fill_ff[ADDR_BITS-1:0]),
      .wr_data (scr_wr_data),
      .rd_en   (scr_rd_en),
      .rd_addr (walk_ff[ADDR_BITS-1:0]),
      .rd_data (scr_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         walk_ff      <= '0;
         fill_ff      <= '0;
         capacity_ff  <= CAP_MAX;
         count_ff     <= '0;
         lowest_ff    <= NONE_TOUCHED;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         walk_ff      <= walk_in;
         fill_ff      <= fill_in;
         capacity_ff  <= capacity_in;
         count_ff     <= count_in;
         lowest_ff    <= lowest_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      walk_in      = walk_ff;
      fill_in      = fill_ff;
      capacity_in  = capacity_ff;
      count_in     = count_ff;
      lowest_in    = lowest_ff;
      done_in      = done_ff;
      req_in       = req_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      elem_wr_en   = 1'b0;
      elem_wr_addr = slot;
      elem_wr_data = EMPTY_CODE;
      elem_rd_en   = 1'b0;
      pend_wr_en   = 1'b0;
      pend_wr_addr = slot;
      pend_wr_data = EMPTY_CODE;
      pend_rd_en   = 1'b0;
      scr_wr_en    = 1'b0;
      scr_wr_data  = pend_rd_data;
      scr_rd_en    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in   = req_data;
               done_in  = 1'b0;
               state_in = ST_EXEC;
            end
         end

         ST_CLEAR: begin
            // Sweep both stores back to the empty marker.
            elem_wr_en   = 1'b1;
            elem_wr_addr = walk_ff[ADDR_BITS-1:0];
            pend_wr_en   = 1'b1;
            pend_wr_addr = walk_ff[ADDR_BITS-1:0];
            walk_in      = walk_ff + CNT_BITS'(1);
            if (walk_ff == CAP_MAX - CNT_BITS'(1)) begin
               walk_in  = '0;
               state_in = ST_IDLE;
            end
         end

         ST_EXEC: begin
            if (need_compact) begin
               walk_in  = '0;
               fill_in  = '0;
               state_in = ST_SCAN_READ;
            end else if (status_now != STATUS_OK) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = status_now;
               rsp_in.read_value  = '0;
               rsp_in.compacted   = done_ff;
               rsp_in.list_length = count_ff;
               state_in           = ST_IDLE;
            end else begin
               rsp_in.status      = STATUS_OK;
               rsp_in.read_value  = '0;
               rsp_in.compacted   = done_ff;
               // A read leaves the touch mark where its compaction put it.
               if (req_ff.kind != KIND_READ && lowest_ff > pos_ext) begin
                  lowest_in = pos_ext;
               end
               case (req_ff.kind)
                  KIND_INSERT: begin
                     pend_wr_en   = 1'b1;
                     pend_wr_data = value_sat;
                     count_in     = count_ff + CNT_BITS'(1);
                     lowest_in    = pos_ext;
                  end
                  KIND_REMOVE: begin
                     elem_wr_en = 1'b1;
                     count_in   = count_ff - CNT_BITS'(1);
                  end
                  KIND_REPLACE: begin
                     elem_wr_en   = 1'b1;
                     elem_wr_data = value_sat;
                  end
                  default: begin
                     elem_rd_en = 1'b1;
                  end
               endcase
               rsp_in.list_length = count_in;
               if (req_ff.kind == KIND_READ) begin
                  state_in = ST_READ_WAIT;
               end else begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end
         end

         ST_SCAN_READ: begin
            elem_rd_en = 1'b1;
            pend_rd_en = 1'b1;
            state_in   = ST_SCAN_PEND;
         end

         ST_SCAN_PEND: begin
            // Drop the pending entry; it lands ahead of the slot's element.
            pend_wr_en = 1'b1;
            if (pend_rd_data != EMPTY_CODE && fill_ff < capacity_ff) begin
               scr_wr_en   = 1'b1;
               scr_wr_data = pend_rd_data;
               fill_in     = fill_ff + CNT_BITS'(1);
            end
            state_in = ST_SCAN_ELEM;
         end

         ST_SCAN_ELEM: begin
            if (elem_rd_data != EMPTY_CODE && fill_ff < capacity_ff) begin
               scr_wr_en   = 1'b1;
               scr_wr_data = elem_rd_data;
               fill_in     = fill_ff + CNT_BITS'(1);
            end
            walk_in  = walk_ff + CNT_BITS'(1);
            state_in = ST_SCAN_READ;
            if (walk_last) begin
               walk_in  = '0;
               state_in = ST_PACK_READ;
            end
         end

         ST_PACK_READ: begin
            scr_rd_en = 1'b1;
            state_in  = ST_PACK_WRITE;
         end

         ST_PACK_WRITE: begin
            // Rewrite zig-zag; logical indices past the compacted length go empty.
            elem_wr_en = 1'b1;
            if (walk_ff < fill_ff) begin
               elem_wr_data = scr_rd_data;
            end
            walk_in  = walk_ff + CNT_BITS'(1);
            state_in = ST_PACK_READ;
            if (walk_last) begin
               walk_in   = '0;
               lowest_in = NONE_TOUCHED;
               done_in   = 1'b1;
               state_in  = ST_EXEC;
            end
         end

         ST_READ_WAIT: begin
            rsp_valid_in      = 1'b1;
            rsp_in.read_value = elem_rd_data;
            state_in          = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A capacity write changes the slot map: empty the list and sweep the stores.
      if (csr_write_en) begin
         capacity_in = cap_clamped;
         count_in    = '0;
         lowest_in   = NONE_TOUCHED;
         walk_in     = '0;
         state_in    = ST_CLEAR;
      end
   end

endmodule

>>> design/lile_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lile_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
